>>> hdl/cau_pkg.sv
// shared types, widths and the saturate helper function for the complex arithmetic unit
package cau_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int SAT_W     = SUM_W + 1;
   localparam int DEN_W     = PROD_W;
   localparam int REM_W     = DEN_W + DATA_W;
   localparam int ADD_W     = DATA_W + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      data_type val;
      logic     ovf;
   } sat_type;

   // per-request info that rides alongside the divider stages
   typedef struct packed {
      logic     is_div;
      logic     dz;
      logic     neg_re;
      logic     neg_im;
      logic     big_re;
      logic     big_im;
      data_type re;
      data_type im;
      logic     ovf;
   } side_type;

   // clamp a wide signed value into the result range
   function automatic sat_type saturate(logic signed [SAT_W-1:0] v);
      sat_type r;
      if ((v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1)) begin
         r.val = v[DATA_W-1:0];
         r.ovf = 1'b0;
      end else begin
         r.val = v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         r.ovf = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> hdl/cau_if.sv
// request and response channel interfaces
interface cau_req_if;
   import cau_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   data_type    a_re;
   data_type    a_im;
   data_type    b_re;
   data_type    b_im;
   modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   import cau_pkg::*;
   logic        valid;
   logic        ready;
   data_type    res_re;
   data_type    res_im;
   logic        overflow;
   logic        div_by_zero;
   modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
   modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface

>>> hdl/complex_arithmetic_unit_top.sv
// complex add, subtract, multiply and divide unit in signed Q8.8
//
//  channel  | dir | handshake       | payload
//  req_if   | in  | valid / ready   | kind, a_re, a_im, b_re, b_im
//  rsp_if   | out | valid / ready   | res_re, res_im, overflow, div_by_zero
//
// one request per cycle while no response waits; every request passes from accept to response
// through two multiply/sum stages, 16 divider stages with the prepare logic ahead of
// the first one, and one output stage
// the 16-stage restoring divider sets the depth; all operations share the pipeline
// reset is synchronous and clears only the valid bits
// while a response waits, the whole pipeline holds and req_if.ready is low
module complex_arithmetic_unit_top (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);
   import cau_pkg::*;

   logic en;

   // stage 1: products and add/sub
   logic                     v1_ff;
   logic [1:0]               kind1_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [ADD_W-1:0]  add_re_ff, add_im_ff;

   // stage 2: sums
   logic                     v2_ff;
   logic [1:0]               kind2_ff;
   logic signed [SUM_W-1:0]  mre_ff, mim_ff, nre_ff, nim_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [ADD_W-1:0]  add2_re_ff, add2_im_ff;

   // stage 3 prepare
   side_type                 side_in;
   logic [REM_W-1:0]         dvd_re, dvd_im;
   logic [SUM_W-1:0]         mag_re, mag_im;
   logic signed [SUM_W-1:0]  msh_re, msh_im;
   sat_type                  s_re, s_im;
   logic [REM_W-1:0]         den_top;

   // divider sideband
   logic                     vd_ff [DATA_W];
   side_type                 sb_ff [DATA_W];
   logic [DATA_W-1:0]        q_re, q_im;

   // output
   logic                     rsp_valid_ff;
   data_type                 res_re_ff, res_im_ff;
   logic                     ovf_ff, dz_ff;
   side_type                 sb_last;
   sat_type                  f_re, f_im;
   logic signed [SAT_W-1:0]  qs_re, qs_im;

   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_if.valid;
      end
      if (en) begin
         kind1_ff  <= req_if.kind;
         p_rr_ff   <= PROD_W'(req_if.a_re) * PROD_W'(req_if.b_re);
         p_ii_ff   <= PROD_W'(req_if.a_im) * PROD_W'(req_if.b_im);
         p_ri_ff   <= PROD_W'(req_if.a_re) * PROD_W'(req_if.b_im);
         p_ir_ff   <= PROD_W'(req_if.a_im) * PROD_W'(req_if.b_re);
         sq_r_ff   <= PROD_W'(req_if.b_re) * PROD_W'(req_if.b_re);
         sq_i_ff   <= PROD_W'(req_if.b_im) * PROD_W'(req_if.b_im);
         if (op_type'(req_if.kind) == OP_SUB) begin
            add_re_ff <= ADD_W'(req_if.a_re) - ADD_W'(req_if.b_re);
            add_im_ff <= ADD_W'(req_if.a_im) - ADD_W'(req_if.b_im);
         end else begin
            add_re_ff <= ADD_W'(req_if.a_re) + ADD_W'(req_if.b_re);
            add_im_ff <= ADD_W'(req_if.a_im) + ADD_W'(req_if.b_im);
         end
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         kind2_ff   <= kind1_ff;
         mre_ff     <= SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
         mim_ff     <= SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         nre_ff     <= SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
         nim_ff     <= SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
         den_ff     <= DEN_W'(sq_r_ff) + DEN_W'(sq_i_ff);
         add2_re_ff <= add_re_ff;
         add2_im_ff <= add_im_ff;
      end
   end

   // stage 3: scale multiply, saturate add/sub, set up division
   always_comb begin
      msh_re  = mre_ff >>> FRAC_BITS;
      msh_im  = mim_ff >>> FRAC_BITS;
      mag_re  = nre_ff[SUM_W-1] ? SUM_W'(-nre_ff) : SUM_W'(nre_ff);
      mag_im  = nim_ff[SUM_W-1] ? SUM_W'(-nim_ff) : SUM_W'(nim_ff);
      dvd_re  = REM_W'(mag_re) << FRAC_BITS;
      dvd_im  = REM_W'(mag_im) << FRAC_BITS;
      den_top = REM_W'(den_ff) << DATA_W;
      if (op_type'(kind2_ff) == OP_MUL) begin
         s_re = saturate(SAT_W'(msh_re));
         s_im = saturate(SAT_W'(msh_im));
      end else begin
         s_re = saturate(SAT_W'(add2_re_ff));
         s_im = saturate(SAT_W'(add2_im_ff));
      end
      side_in.is_div = (op_type'(kind2_ff) == OP_DIV);
      side_in.dz     = (den_ff == '0);
      side_in.neg_re = nre_ff[SUM_W-1];
      side_in.neg_im = nim_ff[SUM_W-1];
      side_in.big_re = (dvd_re >= den_top);
      side_in.big_im = (dvd_im >= den_top);
      side_in.re     = s_re.val;
      side_in.im     = s_im.val;
      side_in.ovf    = s_re.ovf || s_im.ovf;
   end

   cau_udiv u_div_re (
      .clock    (clock),
      .en       (en),
      .dividend (dvd_re),
      .divisor  (den_ff),
      .quot     (q_re)
   );

   cau_udiv u_div_im (
      .clock    (clock),
      .en       (en),
      .dividend (dvd_im),
      .divisor  (den_ff),
      .quot     (q_im)
   );

   // sideband line matching the divider depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DATA_W; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v2_ff;
         for (int k = 1; k < DATA_W; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
      if (en) begin
         sb_ff[0] <= side_in;
         for (int k = 1; k < DATA_W; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // final sign and saturation of the quotient
   always_comb begin
      sb_last = sb_ff[DATA_W-1];
      qs_re   = sb_last.neg_re ? -SAT_W'({1'b0, q_re}) : SAT_W'({1'b0, q_re});
      qs_im   = sb_last.neg_im ? -SAT_W'({1'b0, q_im}) : SAT_W'({1'b0, q_im});
      f_re    = saturate(qs_re);
      f_im    = saturate(qs_im);
      if (sb_last.big_re) begin
         f_re.ovf = 1'b1;
         f_re.val = sb_last.neg_re ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      if (sb_last.big_im) begin
         f_im.ovf = 1'b1;
         f_im.val = sb_last.neg_im ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_ff[DATA_W-1];
      end
      if (en) begin
         if (!sb_last.is_div) begin
            res_re_ff <= sb_last.re;
            res_im_ff <= sb_last.im;
            ovf_ff    <= sb_last.ovf;
            dz_ff     <= 1'b0;
         end else if (sb_last.dz) begin
            res_re_ff <= '0;
            res_im_ff <= '0;
            ovf_ff    <= 1'b0;
            dz_ff     <= 1'b1;
         end else begin
            res_re_ff <= f_re.val;
            res_im_ff <= f_im.val;
            ovf_ff    <= f_re.ovf || f_im.ovf;
            dz_ff     <= 1'b0;
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.res_re      = res_re_ff;
   assign rsp_if.res_im      = res_im_ff;
   assign rsp_if.overflow    = ovf_ff;
   assign rsp_if.div_by_zero = dz_ff;

   // checks
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.div_by_zero |->
         (rsp_if.res_re == '0) && (rsp_if.res_im == '0) && !rsp_if.overflow)
      else $error("divide by zero response not cleared");

   a_ovf_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.overflow |->
         (rsp_if.res_re == {1'b1, {(DATA_W-1){1'b0}}}) ||
         (rsp_if.res_re == {1'b0, {(DATA_W-1){1'b1}}}) ||
         (rsp_if.res_im == {1'b1, {(DATA_W-1){1'b0}}}) ||
         (rsp_if.res_im == {1'b0, {(DATA_W-1){1'b1}}}))
      else $error("overflow without a saturated part");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

>>> hdl/cau_udiv.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module cau_udiv (
   input  logic                        clock,
   input  logic                        en,
   input  logic [cau_pkg::REM_W-1:0]   dividend,
   input  logic [cau_pkg::DEN_W-1:0]   divisor,
   output logic [cau_pkg::DATA_W-1:0]  quot
);
   import cau_pkg::*;

   logic [REM_W-1:0]  rem_ff [DATA_W];
   logic [REM_W-1:0]  rem_in [DATA_W];
   logic [DEN_W-1:0]  den_ff [DATA_W];
   logic [DEN_W-1:0]  den_in [DATA_W];
   logic [DATA_W-1:0] quo_ff [DATA_W];
   logic [DATA_W-1:0] quo_in [DATA_W];

   // each stage tries the divisor shifted to its quotient bit
   always_comb begin
      logic [REM_W-1:0]  r;
      logic [DEN_W-1:0]  d;
      logic [DATA_W-1:0] q;
      logic [REM_W-1:0]  trial;
      for (int k = 0; k < DATA_W; k++) begin
         if (k == 0) begin
            r = dividend;
            d = divisor;
            q = '0;
         end else begin
            r = rem_ff[k-1];
            d = den_ff[k-1];
            q = quo_ff[k-1];
         end
         trial = REM_W'(d) << (DATA_W - 1 - k);
         if (r >= trial) begin
            r = r - trial;
            q[DATA_W-1-k] = 1'b1;
         end
         rem_in[k] = r;
         den_in[k] = d;
         quo_in[k] = q;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DATA_W; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quot = quo_ff[DATA_W-1];

endmodule

>>> sim/tb_complex_arithmetic_unit_top.sv
// testbench for the complex arithmetic unit: random and directed requests checked against a predictor
module tb_complex_arithmetic_unit_top;
   import cau_pkg::*;

   typedef struct packed {
      data_type re;
      data_type im;
      logic     ovf;
      logic     dz;
   } cplx_result;

   // one saturation step of the predictor
   function automatic data_type clamp16(longint v, ref logic ovf);
      if (v > 32767) begin
         ovf = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         ovf = 1'b1;
         return 16'sh8000;
      end
      return data_type'(v);
   endfunction

   // expected complex result for one request
   function automatic cplx_result complex_result(op_type op, data_type ar_i, data_type ai_i,
                                                 data_type br_i, data_type bi_i);
      cplx_result r;
      longint ar, ai, br, bi, re, im, den;
      logic ovf;
      ar = ar_i; ai = ai_i; br = br_i; bi = bi_i;
      re = 0; im = 0; ovf = 1'b0;
      r.dz = 1'b0;
      case (op)
         OP_ADD: begin
            re = ar + br; im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br; im = ai - bi;
         end
         OP_MUL: begin
            re = (ar * br - ai * bi) >>> FRAC_BITS;
            im = (ar * bi + ai * br) >>> FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               re = ((ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS)) / den;
               im = ((ai * br - ar * bi) * (64'sd1 <<< FRAC_BITS)) / den;
            end
         end
      endcase
      r.re = clamp16(re, ovf);
      r.im = clamp16(im, ovf);
      r.ovf = ovf;
      return r;
   endfunction

   // expected results in order, compared against the response channel
   class result_board;
      cplx_result pending[$];
      int errors;

      function void note_request(op_type op, data_type ar, data_type ai, data_type br,
                                 data_type bi);
         pending.push_back(complex_result(op, ar, ai, br, bi));
      endfunction

      function void check_response(cplx_result got);
         cplx_result exp_r;
         if (pending.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.re !== exp_r.re) begin
            $display("%0t res_re expected %0d actual %0d", $realtime, exp_r.re, got.re);
            errors++;
         end
         if (got.im !== exp_r.im) begin
            $display("%0t res_im expected %0d actual %0d", $realtime, exp_r.im, got.im);
            errors++;
         end
         if (got.ovf !== exp_r.ovf) begin
            $display("%0t overflow expected %0b actual %0b", $realtime, exp_r.ovf, got.ovf);
            errors++;
         end
         if (got.dz !== exp_r.dz) begin
            $display("%0t div_by_zero expected %0b actual %0b", $realtime, exp_r.dz, got.dz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   stall_on = 1'b1;
   result_board board;

   cau_req_if req_if ();
   cau_rsp_if rsp_if ();

   complex_arithmetic_unit_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.kind = OP_ADD;
      req_if.a_re = '0;
      req_if.a_im = '0;
      req_if.b_re = '0;
      req_if.b_im = '0;
      rsp_if.ready = 1'b0;
      board = new();
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stall pattern and response check
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_response({rsp_if.res_re, rsp_if.res_im, rsp_if.overflow,
                               rsp_if.div_by_zero});
      if (!stall_on)
         rsp_if.ready <= 1'b1;
      else
         rsp_if.ready <= (cycles % 23 < 17) && ($urandom_range(0, 3) != 0);
   end

   // drive one request and wait for its acceptance
   task automatic send_request(op_type op, data_type ar, data_type ai, data_type br,
                               data_type bi);
      req_if.valid <= 1'b1;
      req_if.kind <= op;
      req_if.a_re <= ar;
      req_if.a_im <= ai;
      req_if.b_re <= br;
      req_if.b_im <= bi;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(op, ar, ai, br, bi);
   endtask

   task automatic go_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // random operand, often at an edge value
   function automatic data_type pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return data_type'($urandom_range(0, 1023)) - 16'sd512;
         4: return data_type'($urandom_range(0, 255));
         default: return data_type'($urandom);
      endcase
   endfunction

   initial begin
      data_type ext[4];
      int burst;
      ext = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes for every operation, zero divisor, tiny divisor
      foreach (ext[i]) begin
         send_request(OP_ADD, ext[i], ext[i], ext[i], ext[i]);
         send_request(OP_SUB, ext[i], ext[3 - i], ext[3 - i], ext[i]);
         send_request(OP_MUL, ext[i], ext[i], ext[3 - i], ext[i]);
         send_request(OP_DIV, ext[i], ext[3 - i], ext[i], ext[3 - i]);
      end
      send_request(OP_DIV, 16'sh1234, -16'sd77, 16'sh0000, 16'sh0000);
      send_request(OP_DIV, 16'sh8000, 16'sh7fff, 16'sh0001, 16'sh0000);
      send_request(OP_DIV, -16'sd300, 16'sd5, 16'sh0000, -16'sd1);
      send_request(OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
      send_request(OP_DIV, 16'sd100, -16'sd100, 16'sd3, 16'sd7);

      // hold off until the pipeline has drained
      go_idle();
      while (board.pending.size() != 0) @(posedge clock);

      // random bursts
      for (int n = 0; n < 1800; n += burst) begin
         burst = $urandom_range(1, 40);
         stall_on = (n % 300) < 240;
         for (int k = 0; k < burst; k++)
            send_request(op_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end
      go_idle();
      stall_on = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
